// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cond must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_AT(lbl, clk, rst, !(cond), msg)

`endif

// File: rtl/core/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared constants and types of the chunked transfer decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ctd_pkg;

   localparam int SIZE_BITS = 32;

   typedef struct packed {
      logic       data_valid;
      logic [7:0] payload_byte;
      logic       message_done;
      logic       size_overflow;
   } rsp_word_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } skid_status_type;

endpackage

`default_nettype wire

// File: rtl/core/ctd_parser.sv
// ----------------------------------------------------------------------------
// ctd_parser
// Chunk framing state and per-word decode; result word for the current byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_wr_data,
   input  wire logic                 step,
   input  wire logic [7:0]           in_byte,
   output ctd_pkg::rsp_word_type     result
);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam int         SB      = ctd_pkg::SIZE_BITS;

   typedef enum logic [1:0] {
      PH_SIZE  = 2'd0,
      PH_DATA  = 2'd1,
      PH_SKIP  = 2'd2,
      PH_FINAL = 2'd3
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [SB-1:0]     count_ff, count_in;
   logic              saw_cr_ff, saw_cr_in;
   logic              skip_ff, skip_in;
   logic              wait_crlf_ff;

   logic              is_hex;
   logic [3:0]        nibble;
   logic [SB-1:0]     count_dec;

   always_comb begin
      is_hex = 1'b1;
      nibble = in_byte[3:0];
      if (in_byte inside {[8'h30:8'h39]}) begin
         nibble = in_byte[3:0];
      end else if (in_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         nibble = in_byte[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   assign count_dec = count_ff - SB'(1);

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      saw_cr_in = saw_cr_ff;
      skip_in   = skip_ff;
      result    = '0;
      case (phase_ff)
         PH_SIZE: begin
            if (in_byte == CHAR_CR) begin
               saw_cr_in = 1'b1;
            end else if (in_byte == CHAR_LF && saw_cr_ff) begin
               saw_cr_in = 1'b0;
               if (count_ff == '0) begin
                  if (wait_crlf_ff) begin
                     phase_in = PH_FINAL;
                     skip_in  = 1'b1;
                  end else begin
                     result.message_done = 1'b1;
                  end
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               saw_cr_in = 1'b0;
               if (is_hex) begin
                  if (count_ff[SB-1 -: 4] != 4'd0) begin
                     count_in             = '1;
                     result.size_overflow = 1'b1;
                  end else begin
                     count_in = {count_ff[SB-5:0], nibble};
                  end
               end
            end
         end
         PH_DATA: begin
            result.data_valid   = 1'b1;
            result.payload_byte = in_byte;
            count_in            = count_dec;
            if (count_dec == '0) begin
               phase_in = PH_SKIP;
               skip_in  = 1'b1;
            end
         end
         PH_SKIP, PH_FINAL: begin
            if (skip_ff) begin
               skip_in = 1'b0;
            end else begin
               result.message_done = (phase_ff == PH_FINAL);
               phase_in            = PH_SIZE;
               count_in            = '0;
               saw_cr_in           = 1'b0;
            end
         end
         default: begin
            phase_in = PH_SIZE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_SIZE;
         count_ff     <= '0;
         saw_cr_ff    <= 1'b0;
         skip_ff      <= 1'b0;
         wait_crlf_ff <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            wait_crlf_ff <= csr_wr_data;
         end
         if (step) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            saw_cr_ff <= saw_cr_in;
            skip_ff   <= skip_in;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/ctd_skid.sv
// ----------------------------------------------------------------------------
// ctd_skid
// Output register plus one skid entry; ready depends only on local state.
// ----------------------------------------------------------------------------
`default_nettype none

module ctd_skid (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire ctd_pkg::rsp_word_type   push_word,
   output logic                         push_ready,
   output logic                         out_valid,
   input  wire logic                    out_ready,
   output ctd_pkg::rsp_word_type        out_word,
   output ctd_pkg::skid_status_type     status
);

   logic                  main_v_ff;
   logic                  skid_v_ff;
   ctd_pkg::rsp_word_type main_ff;
   ctd_pkg::rsp_word_type skid_ff;
   logic                  pop;

   assign pop        = main_v_ff && out_ready;
   assign push_ready = !skid_v_ff;
   assign out_valid  = main_v_ff;
   assign out_word   = main_ff;

   assign status.main_valid = main_v_ff;
   assign status.skid_valid = skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (push) begin
         if (!main_v_ff || pop) begin
            main_v_ff <= 1'b1;
         end else begin
            skid_v_ff <= 1'b1;
         end
      end else if (pop) begin
         if (skid_v_ff) begin
            skid_v_ff <= 1'b0;
         end else begin
            main_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         if (!main_v_ff || pop) begin
            main_ff <= push_word;
         end else begin
            skid_ff <= push_word;
         end
      end else if (pop && skid_v_ff) begin
         main_ff <= skid_ff;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/chunked_transfer_decoder.sv
// Each result word is registered in the output register or, if stalled, the skid entry.
// One word per cycle while req_ready is high; per-byte framing is one registered step.
// req_ready is low only while the skid entry behind the output register is full.
// Reset (synchronous, active high) returns to the size-line phase with a zero
// count, clears both output entries and sets wait_crlf_ff to 1.
// ----------------------------------------------------------------------------
// chunked_transfer_decoder
// Strips chunk framing from a chunked transfer body, one byte per word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module chunked_transfer_decoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_data_valid,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_message_done,
   output logic            rsp_size_overflow,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);

   logic                      req_accept;
   ctd_pkg::rsp_word_type     step_word;
   ctd_pkg::rsp_word_type     out_word;
   ctd_pkg::skid_status_type  skid_status;

   assign req_accept = req_valid && req_ready;

   ctd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (req_accept),
      .in_byte     (req_in_byte),
      .result      (step_word)
   );

   ctd_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_word  (step_word),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_word   (out_word),
      .status     (skid_status)
   );

   assign rsp_data_valid    = out_word.data_valid;
   assign rsp_payload_byte  = out_word.payload_byte;
   assign rsp_message_done  = out_word.message_done;
   assign rsp_size_overflow = out_word.size_overflow;

   `ASSERT_AT(a_skid_behind_main, clock, reset,
      skid_status.skid_valid |-> skid_status.main_valid, "skid entry without output entry")
   `ASSERT_AT(a_stall_fills_skid, clock, reset,
      (req_accept && rsp_valid && !rsp_ready) |=> !req_ready, "stalled push lost")
   `ASSERT_NEVER(a_data_not_done, clock, reset,
      rsp_valid && rsp_data_valid && rsp_message_done, "data word flagged as done")
   `ASSERT_NEVER(a_data_not_ovf, clock, reset,
      rsp_valid && rsp_data_valid && rsp_size_overflow, "data word flagged overflow")

endmodule

`default_nettype wire

// File: test/chunked_transfer_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_tb
// Self-checking bench for the chunked transfer decoder. Feeds chunk framing
// byte by byte, including directed line-end corner cases, random well-formed
// messages with noisy size lines, both trailer modes and a saturating size.
// Every accepted word is decoded by a local model and each rsp word is
// compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module chunked_transfer_decoder_tb;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam int RANDOM_TARGET = 480;

   typedef enum logic [1:0] {ST_SIZE_LINE, ST_PAYLOAD, ST_TRAILER, ST_FINAL} decode_phase_type;
   typedef enum int {RX_OPEN, RX_TOGGLE, RX_RANDOM, RX_BURSTY} rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic       rsp_data_valid;
   logic [7:0] rsp_payload_byte;
   logic       rsp_message_done;
   logic       rsp_size_overflow;
   logic       csr_wr_en = 1'b0;
   logic       csr_wr_data = 1'b0;

   // decoder model state
   decode_phase_type              dec_phase;
   logic [ctd_pkg::SIZE_BITS-1:0] dec_count;
   logic                          dec_saw_cr;
   logic                          dec_skip;
   logic                          wait_mode;

   ctd_pkg::rsp_word_type predicted_words[$];

   bit          steady = 1'b0;
   int          burst_left = 0;
   int          words_sent = 0;
   int          err_count = 0;
   int          result_count = 0;
   int          payloads_seen = 0;
   int          messages_seen = 0;
   int          overflows_seen = 0;
   int          stall_cycle = 0;
   rx_mode_type stall_mode = RX_OPEN;

   chunked_transfer_decoder uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_data_valid    (rsp_data_valid),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_message_done  (rsp_message_done),
      .rsp_size_overflow (rsp_size_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #2 clock = ~clock;

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic ctd_pkg::rsp_word_type decode_byte(input logic [7:0] b);
      ctd_pkg::rsp_word_type w;
      int                    d;
      w = '0;
      d = hex_value(b);
      case (dec_phase)
         ST_SIZE_LINE: begin
            if (b == CH_CR) begin
               dec_saw_cr = 1'b1;
            end else if (b == CH_LF && dec_saw_cr) begin
               dec_saw_cr = 1'b0;
               if (dec_count == '0) begin
                  if (wait_mode) begin
                     dec_phase = ST_FINAL;
                     dec_skip  = 1'b1;
                  end else begin
                     w.message_done = 1'b1;
                  end
               end else begin
                  dec_phase = ST_PAYLOAD;
               end
            end else begin
               dec_saw_cr = 1'b0;
               if (d >= 0) begin
                  if (dec_count[ctd_pkg::SIZE_BITS-1 -: 4] != 4'h0) begin
                     dec_count       = '1;
                     w.size_overflow = 1'b1;
                  end else begin
                     dec_count = {dec_count[ctd_pkg::SIZE_BITS-5:0], 4'(d)};
                  end
               end
            end
         end
         ST_PAYLOAD: begin
            w.data_valid   = 1'b1;
            w.payload_byte = b;
            dec_count      = dec_count - 1'b1;
            if (dec_count == '0) begin
               dec_phase = ST_TRAILER;
               dec_skip  = 1'b1;
            end
         end
         default: begin
            // two unchecked bytes after data or after the zero-size line
            if (dec_skip) begin
               dec_skip = 1'b0;
            end else begin
               w.message_done = (dec_phase == ST_FINAL);
               dec_phase      = ST_SIZE_LINE;
               dec_count      = '0;
               dec_saw_cr     = 1'b0;
            end
         end
      endcase
      return w;
   endfunction

   task automatic report_mismatch(input string field, input int got_v, input int exp_v);
      err_count++;
      $display("ERROR result %0d %s: got %0h expected %0h", result_count, field, got_v, exp_v);
   endtask

   // model update and result check
   always @(posedge clock) begin : result_monitor
      ctd_pkg::rsp_word_type exp_w;
      if (reset) begin
         dec_phase  = ST_SIZE_LINE;
         dec_count  = '0;
         dec_saw_cr = 1'b0;
         dec_skip   = 1'b0;
         wait_mode  = 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (predicted_words.size() == 0) begin
               report_mismatch("unexpected word", 1, 0);
            end else begin
               exp_w = predicted_words.pop_front();
               if (rsp_data_valid !== exp_w.data_valid)
                  report_mismatch("data_valid", rsp_data_valid, exp_w.data_valid);
               if (rsp_payload_byte !== exp_w.payload_byte)
                  report_mismatch("payload_byte", rsp_payload_byte, exp_w.payload_byte);
               if (rsp_message_done !== exp_w.message_done)
                  report_mismatch("message_done", rsp_message_done, exp_w.message_done);
               if (rsp_size_overflow !== exp_w.size_overflow)
                  report_mismatch("size_overflow", rsp_size_overflow, exp_w.size_overflow);
               payloads_seen  += exp_w.data_valid;
               messages_seen  += exp_w.message_done;
               overflows_seen += exp_w.size_overflow;
            end
         end
         if (req_valid && req_ready)
            predicted_words.push_back(decode_byte(req_in_byte));
         if (csr_wr_en)
            wait_mode = csr_wr_data;
      end
   end

   // rsp backpressure
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_ready <= 1'b1;
      end else begin
         if (stall_cycle % 48 == 0)
            stall_mode = rx_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_TOGGLE: rsp_ready <= stall_cycle[0];
            RX_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            default:   rsp_ready <= (stall_cycle % 9) < 3;
         endcase
      end
      stall_cycle++;
   end

   task automatic send_word(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         if (steady)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(8, 20);
         else
            gap = $urandom_range(0, 3);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic send_crlf();
      send_word(CH_CR);
      send_word(CH_LF);
   endtask

   // any byte that is neither a hex digit nor a line-end character
   task automatic send_junk();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (hex_value(b) >= 0 || b == CH_CR || b == CH_LF);
      send_word(b);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (result_count != words_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_mode(input logic v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_size_line(input int n, input bit noisy);
      int         nd;
      int         i;
      logic [3:0] nib;
      logic [7:0] c;
      if (noisy) begin
         // lone LF, then CR not followed by LF
         send_word(CH_LF);
         send_word(CH_CR);
         send_junk();
      end
      repeat ($urandom_range(0, 2)) send_word("0");
      nd = 1;
      while ((n >> (4 * nd)) != 0) nd++;
      for (i = nd - 1; i >= 0; i--) begin
         nib = 4'(n >> (4 * i));
         if (nib < 4'd10)
            c = 8'("0") + 8'(nib);
         else
            c = ($urandom_range(0, 1) ? 8'("a") : 8'("A")) + 8'(nib) - 8'd10;
         send_word(c);
      end
      if ($urandom_range(0, 3) == 0) begin
         send_word(";");
         repeat ($urandom_range(1, 4)) send_junk();
      end
      if (noisy)
         send_word(CH_CR);
      send_crlf();
   endtask

   task automatic send_message(input bit trailer_mode);
      int chunks;
      int sz;
      int k;
      chunks = $urandom_range(0, 3);
      for (k = 0; k < chunks; k++) begin
         sz = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 90) : $urandom_range(1, 20);
         send_size_line(sz, $urandom_range(0, 9) == 0);
         repeat (sz) send_word(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 4) == 0) begin
            send_word(8'($urandom));
            send_word(8'($urandom));
         end else begin
            send_crlf();
         end
         if ($urandom_range(0, 19) == 0)
            wait_for_results();
      end
      send_size_line(0, $urandom_range(0, 9) == 0);
      if (trailer_mode && $urandom_range(0, 4) == 0) begin
         send_word(8'($urandom));
         send_word(8'($urandom));
      end else if (trailer_mode || $urandom_range(0, 3) == 0) begin
         send_crlf();
      end
   endtask

   task automatic test_basic_chunks();
      send_word("3");
      send_word(";");
      send_word("x");
      send_crlf();
      send_word(8'h00);
      send_word(8'hFF);
      send_word(CH_CR);
      send_crlf();
      send_word("0");
      send_crlf();
      send_crlf();
   endtask

   task automatic test_line_end_cases();
      send_word(CH_LF);
      send_word("1");
      send_word(CH_CR);
      send_word("Z");
      send_word(CH_CR);
      send_word(CH_CR);
      send_word(CH_LF);
      send_word("Q");
      send_word("x");
      send_word("y");
      wait_for_results();
      write_mode(1'b0);
      send_word("0");
      send_crlf();
   endtask

   task automatic test_random_messages();
      int ph;
      bit m;
      ph = 0;
      while (words_sent < RANDOM_TARGET) begin
         wait_for_results();
         m = (ph < 2) ? ph[0] : 1'($urandom_range(0, 1));
         steady = (ph == 2);
         write_mode(m);
         repeat ($urandom_range(2, 5)) send_message(m);
         ph++;
      end
      steady = 1'b0;
   endtask

   // leaves the block in a huge payload phase, so it runs last
   task automatic test_size_overflow();
      wait_for_results();
      write_mode(1'b1);
      send_word("0");
      send_word("0");
      repeat (ctd_pkg::SIZE_BITS / 4) send_word("F");
      send_word("a");
      send_word("G");
      send_word("1");
      send_crlf();
      repeat (40) send_word(8'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_basic_chunks();
      test_line_end_cases();
      test_random_messages();
      test_size_overflow();
      wait_for_results();
      $display("Run: %0d words in, %0d words checked, %0d payload bytes, %0d messages ended",
               words_sent, result_count, payloads_seen, messages_seen);
      $display("Run: %0d size overflows, both trailer modes, noisy lines, stalls on both sides",
               overflows_seen);
      if (err_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #200_000;
      $display("timeout with %0d words outstanding", predicted_words.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
